@@ rtl/core/vzz_pkg.sv @@
// vzz_pkg: shared constants, types and helpers of the varint / zigzag codec
// no dependencies; used by every file under rtl/core

package vzz_pkg;

    localparam int VALUE_BITS       = 64;
    localparam int NARROW_BITS      = 32;
    localparam int GROUP_BITS       = 7;
    localparam int MAX_BYTES_WIDE   = (VALUE_BITS + GROUP_BITS - 1) / GROUP_BITS;
    localparam int MAX_BYTES_NARROW = (NARROW_BITS + GROUP_BITS - 1) / GROUP_BITS;
    localparam int GC_W             = $clog2(MAX_BYTES_WIDE + 1);
    localparam int IDX_W            = $clog2(MAX_BYTES_WIDE);
    localparam int CFG_IDX_W        = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRECTION = 2'd0,
        CFG_ZIGZAG    = 2'd1,
        CFG_WIDE      = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic zigzag;
        logic wide;
    } t_cfg;

    typedef struct packed {
        logic                  valid;
        logic                  too_long;
        logic [VALUE_BITS-1:0] value;
    } t_dec_res;

    function automatic logic [VALUE_BITS-1:0] width_mask(input logic wide);
        logic [VALUE_BITS-1:0] m;
        m = '0;
        if (wide) begin
            m = '1;
        end else begin
            m[NARROW_BITS-1:0] = '1;
        end
        return m;
    endfunction

endpackage

@@ rtl/core/vzz_in_if.sv @@
// vzz_in_if: input channel of the codec, valid / ready with value and byte payload
// depends on vzz_pkg

interface vzz_in_if;
    logic                           valid;
    logic                           ready;
    logic [vzz_pkg::VALUE_BITS-1:0] value_in;
    logic [7:0]                     byte_in;

    modport source (output valid, output value_in, output byte_in, input ready);
    modport sink   (input valid, input value_in, input byte_in, output ready);
endinterface

@@ rtl/core/vzz_out_if.sv @@
// vzz_out_if: result channel of the codec, valid / ready with byte or value payload
// depends on vzz_pkg

interface vzz_out_if;
    logic                           valid;
    logic                           ready;
    logic [7:0]                     byte_out;
    logic [vzz_pkg::VALUE_BITS-1:0] value_out;
    logic                           last;
    logic                           too_long;

    modport source (output valid, output byte_out, output value_out, output last,
                    output too_long, input ready);
    modport sink   (input valid, input byte_out, input value_out, input last,
                    input too_long, output ready);
endinterface

@@ rtl/core/vzz_enc.sv @@
// vzz_enc: encoder, loads one mapped value into a shift register and emits
// one 7-bit group per cycle while each byte is taken; depends on vzz_pkg

module vzz_enc (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  vzz_pkg::t_cfg                  i_cfg,
    input  logic                           i_load,
    input  logic [vzz_pkg::VALUE_BITS-1:0] i_value,
    input  logic                           i_take,
    output logic                           o_busy,
    output logic [7:0]                     o_byte,
    output logic                           o_last
);

    localparam int VB = vzz_pkg::VALUE_BITS;
    localparam int GB = vzz_pkg::GROUP_BITS;

    logic          r_busy, n_busy;
    logic [VB-1:0] r_sh, n_sh;
    logic          more;
    logic [VB-1:0] mask;
    logic [VB-1:0] masked;
    logic          sign;

    assign more = |r_sh[VB-1:GB];
    assign mask = vzz_pkg::width_mask(i_cfg.wide);

    always_comb begin
        masked = i_value & mask;
        sign   = i_cfg.wide ? masked[VB-1] : masked[vzz_pkg::NARROW_BITS-1];
        n_sh   = r_sh;
        n_busy = r_busy;
        if (i_load) begin
            n_busy = 1'b1;
            if (i_cfg.zigzag) begin
                n_sh = ((masked << 1) ^ {VB{sign}}) & mask;
            end else begin
                n_sh = masked;
            end
        end else if (i_take) begin
            if (more) begin
                n_sh = r_sh >> GB;
            end else begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_sh <= n_sh;
    end

    assign o_busy = r_busy;
    assign o_byte = {more, r_sh[GB-1:0]};
    assign o_last = !more;

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && i_take && !more && !i_load) |=> !r_busy)
        else $error("encoder still busy after last byte");

    a_shift_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && i_take && more && !i_load) |=> (r_busy && r_sh == ($past(r_sh) >> GB)))
        else $error("encoder did not advance one group");

endmodule

@@ rtl/core/vzz_dec.sv @@
// vzz_dec: decoder, drops each byte's group into its slot and emits the
// value on a terminating or overlong byte; depends on vzz_pkg

module vzz_dec (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  vzz_pkg::t_cfg    i_cfg,
    input  logic             i_load,
    input  logic [7:0]       i_byte,
    input  logic             i_take,
    output vzz_pkg::t_dec_res o_res
);

    localparam int VB    = vzz_pkg::VALUE_BITS;
    localparam int GB    = vzz_pkg::GROUP_BITS;
    localparam int MAXW  = vzz_pkg::MAX_BYTES_WIDE;
    localparam int GC_W  = vzz_pkg::GC_W;
    localparam int IDX_W = vzz_pkg::IDX_W;
    localparam logic [GC_W-1:0] MAX_WIDE   = GC_W'(vzz_pkg::MAX_BYTES_WIDE);
    localparam logic [GC_W-1:0] MAX_NARROW = GC_W'(vzz_pkg::MAX_BYTES_NARROW);

    logic [GB-1:0]      r_slots [MAXW];
    logic [GB-1:0]      n_slots [MAXW];
    logic [GC_W-1:0]    r_gc;
    logic [GC_W-1:0]    gc_inc;
    logic [GC_W-1:0]    max_bytes;
    logic [MAXW*GB-1:0] flat;
    logic [VB-1:0]      mask;
    logic [VB-1:0]      acc;
    logic [VB-1:0]      value;
    logic               done;
    logic               overlong;
    logic               emit;
    logic               r_valid;
    logic               r_too_long;
    logic [VB-1:0]      r_value;

    assign mask      = vzz_pkg::width_mask(i_cfg.wide);
    assign gc_inc    = r_gc + GC_W'(1);
    assign max_bytes = i_cfg.wide ? MAX_WIDE : MAX_NARROW;
    assign done      = !i_byte[7];
    assign overlong  = !done && (gc_inc >= max_bytes);
    assign emit      = i_load && (done || overlong);

    always_comb begin
        for (int k = 0; k < MAXW; k++) begin
            n_slots[k] = r_slots[k];
        end
        n_slots[r_gc[IDX_W-1:0]] = i_byte[GB-1:0];
        for (int k = 0; k < MAXW; k++) begin
            flat[k*GB +: GB] = n_slots[k];
        end
        acc = flat[VB-1:0] & mask;
        if (i_cfg.zigzag) begin
            value = ((acc >> 1) ^ {VB{acc[0]}}) & mask;
        end else begin
            value = acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gc    <= '0;
            r_valid <= 1'b0;
            for (int k = 0; k < MAXW; k++) begin
                r_slots[k] <= '0;
            end
        end else begin
            if (i_load) begin
                if (emit) begin
                    r_gc <= '0;
                    for (int k = 0; k < MAXW; k++) begin
                        r_slots[k] <= '0;
                    end
                end else begin
                    r_gc <= gc_inc;
                    for (int k = 0; k < MAXW; k++) begin
                        r_slots[k] <= n_slots[k];
                    end
                end
            end
            if (emit) begin
                r_valid <= 1'b1;
            end else if (i_take) begin
                r_valid <= 1'b0;
            end
        end
        if (emit) begin
            r_value    <= value;
            r_too_long <= overlong;
        end
    end

    assign o_res.valid    = r_valid;
    assign o_res.too_long = r_too_long;
    assign o_res.value    = r_value;

    a_gc_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gc < MAX_WIDE)
        else $error("group count past the widest run");

    a_emit_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_gc == '0 && r_valid))
        else $error("decoder did not restart after a value");

endmodule

@@ rtl/core/varint_zigzag_codec_core.sv @@
// varint_zigzag_codec_core: top level of the base-128 varint codec with zigzag
// depends on vzz_pkg, vzz_in_if, vzz_out_if, vzz_enc, vzz_dec
//
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    value_in[63:0], byte_in[7:0]
//  o_out     out  valid/ready    byte_out[7:0], value_out[63:0], last, too_long
//  i_cfg_*   in   we only        index[1:0], wdata[0]
//
// encode: one value per run, one byte per cycle out of the encoder shift
// register while o_out is ready; no new value until the last byte is taken
// decode: one byte per cycle; a finished value sits in the result register
// and further bytes are taken once it is consumed or while it is taken
// reset is synchronous and clears config to encode, no zigzag, wide mode

module varint_zigzag_codec_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    vzz_in_if.sink                          i_in,
    vzz_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [vzz_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [0:0]                      i_cfg_wdata
);

    logic              r_direction;
    vzz_pkg::t_cfg     r_cfg;
    logic              enc_busy;
    logic [7:0]        enc_byte;
    logic              enc_last;
    vzz_pkg::t_dec_res dec_res;
    logic              in_xfer;
    logic              out_xfer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction  <= 1'b0;
            r_cfg.zigzag <= 1'b0;
            r_cfg.wide   <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                vzz_pkg::CFG_DIRECTION: r_direction  <= i_cfg_wdata[0];
                vzz_pkg::CFG_ZIGZAG:    r_cfg.zigzag <= i_cfg_wdata[0];
                vzz_pkg::CFG_WIDE:      r_cfg.wide   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign i_in.ready = r_direction ? (!dec_res.valid || o_out.ready) : !enc_busy;
    assign in_xfer    = i_in.valid && i_in.ready;
    assign out_xfer   = o_out.valid && o_out.ready;

    vzz_enc u_enc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_load  (in_xfer && !r_direction),
        .i_value (i_in.value_in),
        .i_take  (out_xfer && !r_direction),
        .o_busy  (enc_busy),
        .o_byte  (enc_byte),
        .o_last  (enc_last)
    );

    vzz_dec u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_load  (in_xfer && r_direction),
        .i_byte  (i_in.byte_in),
        .i_take  (out_xfer && r_direction),
        .o_res   (dec_res)
    );

    always_comb begin
        if (r_direction) begin
            o_out.valid     = dec_res.valid;
            o_out.byte_out  = '0;
            o_out.value_out = dec_res.value;
            o_out.last      = 1'b1;
            o_out.too_long  = dec_res.too_long;
        end else begin
            o_out.valid     = enc_busy;
            o_out.byte_out  = enc_byte;
            o_out.value_out = '0;
            o_out.last      = enc_last;
            o_out.too_long  = 1'b0;
        end
    end

endmodule

@@ tb/sv/tb.sv @@
// tb: self-checking testbench of varint_zigzag_codec_core, encode and decode paths
// depends on vzz_pkg, vzz_in_if, vzz_out_if and the core; stimulus is directed then random
`timescale 1ns / 100ps

module tb;

    localparam logic [vzz_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef struct packed {
        logic [7:0]                     octet;
        logic [vzz_pkg::VALUE_BITS-1:0] value;
        logic                           last;
        logic                           too_long;
    } t_codec_res;

    class t_codec_scoreboard;
        bit                             dir;
        bit                             zz;
        bit                             wide;
        logic [vzz_pkg::VALUE_BITS-1:0] acc;
        logic [3:0]                     groups;
        t_codec_res                     pending_q[$];
        int                             mismatches;

        function new();
            dir        = 1'b0;
            zz         = 1'b0;
            wide       = 1'b1;
            acc        = '0;
            groups     = '0;
            mismatches = 0;
        endfunction

        function void apply_reg(logic [vzz_pkg::CFG_IDX_W-1:0] idx, logic d);
            case (idx)
                vzz_pkg::CFG_DIRECTION: dir  = d;
                vzz_pkg::CFG_ZIGZAG:    zz   = d;
                vzz_pkg::CFG_WIDE:      wide = d;
                default: ;
            endcase
        endfunction

        function void push_res(logic [7:0] o, logic [vzz_pkg::VALUE_BITS-1:0] v, logic l,
                               logic t);
            t_codec_res r;
            r.octet    = o;
            r.value    = v;
            r.last     = l;
            r.too_long = t;
            pending_q  = {pending_q, r};
        endfunction

        // one accepted input transaction
        function void note_input(logic [vzz_pkg::VALUE_BITS-1:0] val, logic [7:0] b);
            int                             w;
            int                             max_groups;
            int                             n;
            int                             sh;
            logic [vzz_pkg::VALUE_BITS-1:0] mask;
            logic [vzz_pkg::VALUE_BITS-1:0] v;
            logic                           done;
            logic                           overlong;
            w          = wide ? vzz_pkg::VALUE_BITS : vzz_pkg::NARROW_BITS;
            max_groups = wide ? vzz_pkg::MAX_BYTES_WIDE : vzz_pkg::MAX_BYTES_NARROW;
            mask       = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
            if (!dir) begin
                v = val & mask;
                if (zz) begin
                    v = ((v << 1) ^ {vzz_pkg::VALUE_BITS{v[w-1]}}) & mask;
                end
                n = 0;
                while (v >= 64'h80 && n < 9) begin
                    push_res({1'b1, v[6:0]}, '0, 1'b0, 1'b0);
                    v = v >> 7;
                    n++;
                end
                push_res(v[7:0], '0, 1'b1, 1'b0);
            end else begin
                sh = int'(groups) * 7;
                if (sh < 64) begin
                    acc = acc | ({57'd0, b[6:0]} << sh);
                end
                groups   = groups + 4'd1;
                done     = !b[7];
                overlong = !done && (int'(groups) >= max_groups);
                if (done || overlong) begin
                    v = acc & mask;
                    if (zz) begin
                        v = ((v >> 1) ^ {vzz_pkg::VALUE_BITS{v[0]}}) & mask;
                    end
                    push_res(8'h00, v, 1'b1, overlong);
                    acc    = '0;
                    groups = '0;
                end
            end
        endfunction

        function void check_result(t_codec_res got);
            t_codec_res exp_r;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t unexpected result: byte %h value %h last %b too_long %b",
                             $realtime, got.octet, got.value, got.last, got.too_long);
                end
                return;
            end
            exp_r = pending_q.pop_front();
            if (got.octet !== exp_r.octet || got.value !== exp_r.value ||
                got.last !== exp_r.last || got.too_long !== exp_r.too_long) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t mismatch: expected byte %h value %h last %b too_long %b",
                             $realtime, exp_r.octet, exp_r.value, exp_r.last, exp_r.too_long);
                    $display("%0t          got      byte %h value %h last %b too_long %b",
                             $realtime, got.octet, got.value, got.last, got.too_long);
                end
            end
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          cfg_we;
    logic [vzz_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [0:0]                    cfg_wdata;

    vzz_in_if  in_ch ();
    vzz_out_if out_ch ();

    t_codec_scoreboard board;
    bit                tx_stall_on;
    bit                rx_stall_on;
    int                hold_request;
    int                items_sent;

    varint_zigzag_codec_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAIL varint_zigzag_codec_core");
        $finish;
    end

    // result side: check accepted transactions, drive ready with stall bursts
    initial begin
        int         stall_left;
        t_codec_res got;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                got.octet    = out_ch.byte_out;
                got.value    = out_ch.value_out;
                got.last     = out_ch.last;
                got.too_long = out_ch.too_long;
                board.check_result(got);
            end
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (rx_stall_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 12);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_item(logic [vzz_pkg::VALUE_BITS-1:0] val, logic [7:0] b);
        int gap;
        if (tx_stall_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.value_in <= val;
        in_ch.byte_in  <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_input(val, b);
        items_sent++;
    endtask

    // sender pauses until every expected transaction has come out
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (board.pending_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_reg(logic [vzz_pkg::CFG_IDX_W-1:0] idx, logic d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= d;
        @(posedge i_clk);
        board.apply_reg(idx, d);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_mode(bit dir, bit zz, bit wide);
        settle();
        set_reg(vzz_pkg::CFG_DIRECTION, dir);
        set_reg(vzz_pkg::CFG_ZIGZAG, zz);
        set_reg(vzz_pkg::CFG_WIDE, wide);
    endtask

    function automatic logic [vzz_pkg::VALUE_BITS-1:0] rand_value();
        logic [vzz_pkg::VALUE_BITS-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: v = v >> $urandom_range(0, 63);
            1: v = ~(v >> $urandom_range(1, 63));
            2: v = v >> $urandom_range(56, 63);
            default: ;
        endcase
        return v;
    endfunction

    // mostly well-formed runs, some overlong runs and loose noise bytes
    task automatic send_decode_run(int max_groups);
        int kind;
        int len;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            send_item({$urandom, $urandom}, 8'($urandom));
        end else if (kind == 1) begin
            repeat (max_groups) send_item({$urandom, $urandom}, 8'h80 | 8'($urandom));
        end else begin
            len = $urandom_range(1, max_groups);
            repeat (len - 1) send_item({$urandom, $urandom}, 8'h80 | 8'($urandom));
            send_item({$urandom, $urandom}, 8'h7f & 8'($urandom));
        end
    endtask

    initial begin
        int  phase;
        int  target;
        int  mode;
        bit  dir;
        bit  zz;
        bit  wide;
        board = new();
        tx_stall_on  = 1'b0;
        rx_stall_on  = 1'b0;
        hold_request = 0;
        items_sent   = 0;
        in_ch.valid    <= 1'b0;
        in_ch.value_in <= '0;
        in_ch.byte_in  <= '0;
        cfg_we         <= 1'b0;
        cfg_index      <= '0;
        cfg_wdata      <= '0;
        i_rst_n        <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // encode extremes, reset config first
        send_item(64'h0, 8'h00);
        send_item(64'h7f, 8'hff);
        send_item(64'h80, 8'h00);
        send_item(64'hffff_ffff_ffff_ffff, 8'h00);
        set_mode(1'b0, 1'b1, 1'b1);
        send_item(64'hffff_ffff_ffff_ffff, 8'h00);
        send_item(64'h7fff_ffff_ffff_ffff, 8'h00);
        send_item(64'h8000_0000_0000_0000, 8'h00);
        set_mode(1'b0, 1'b1, 1'b0);
        send_item(64'hffff_ffff_8000_0000, 8'h00);
        send_item(64'h0000_0001_7fff_ffff, 8'h00);
        set_mode(1'b0, 1'b0, 1'b0);
        send_item(64'hffff_ffff_ffff_ffff, 8'h00);

        // decode: single byte, group bits past the width, overlong run
        set_mode(1'b1, 1'b0, 1'b0);
        send_item(64'h0, 8'h00);
        repeat (4) send_item(64'h0, 8'hff);
        send_item(64'h0, 8'h7f);
        repeat (5) send_item(64'h0, 8'h80);

        // partial run kept across an encode and a width change
        set_mode(1'b1, 1'b1, 1'b1);
        repeat (6) send_item(64'h0, 8'h80);
        settle();
        set_reg(vzz_pkg::CFG_DIRECTION, 1'b0);
        send_item(64'h1234_5678_9abc_def0, 8'h00);
        settle();
        set_reg(vzz_pkg::CFG_DIRECTION, 1'b1);
        set_reg(vzz_pkg::CFG_WIDE, 1'b0);
        send_item(64'h0, 8'h81);
        settle();
        set_reg(CFG_UNUSED_IDX, 1'b1);

        // long receiver hold while the sender keeps offering long runs
        set_mode(1'b0, 1'b0, 1'b1);
        tx_stall_on  = 1'b1;
        rx_stall_on  = 1'b1;
        hold_request = 400;
        repeat (24) send_item(~(rand_value() >> $urandom_range(0, 3)), 8'($urandom));
        settle();

        for (phase = 0; phase < 16; phase++) begin
            mode = (phase < 8) ? phase : $urandom_range(0, 7);
            dir  = mode[0];
            zz   = mode[1];
            wide = mode[2];
            if (phase >= 14) begin
                tx_stall_on = 1'b0;
                rx_stall_on = 1'b0;
            end else begin
                tx_stall_on = ($urandom_range(0, 3) != 0);
                rx_stall_on = ($urandom_range(0, 3) != 0);
            end
            set_mode(dir, zz, wide);
            if ($urandom_range(0, 3) == 0) begin
                set_reg(CFG_UNUSED_IDX, 1'($urandom));
            end
            target = items_sent + 23;
            while (items_sent < target) begin
                if (dir) begin
                    send_decode_run(wide ? vzz_pkg::MAX_BYTES_WIDE
                                         : vzz_pkg::MAX_BYTES_NARROW);
                end else begin
                    send_item(rand_value(), 8'($urandom));
                end
            end
        end

        settle();
        repeat (16) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("PASS varint_zigzag_codec_core");
        end else begin
            $display("FAIL varint_zigzag_codec_core");
        end
        $finish;
    end

endmodule
